>>> src/trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types, codes and the control program of the request token parser.
// ----------------------------------------------------------------------------
package trp_pkg;

  // default element buffer depth
  localparam int unsigned MaxElementsDef = 8;

  // fixed field widths
  localparam int unsigned KindW  = 5;
  localparam int unsigned StepW  = 4;
  localparam int unsigned ErrW   = 4;
  localparam int unsigned NumCls = 11;

  // token kinds
  localparam logic [KindW-1:0] KIND_OUTPUT = 5'd0;
  localparam logic [KindW-1:0] KIND_INPUT  = 5'd1;
  localparam logic [KindW-1:0] KIND_READ   = 5'd2;
  localparam logic [KindW-1:0] KIND_OPEN   = 5'd3;
  localparam logic [KindW-1:0] KIND_CLOSE  = 5'd4;
  localparam logic [KindW-1:0] KIND_COMMA  = 5'd5;
  localparam logic [KindW-1:0] KIND_COLON  = 5'd6;
  localparam logic [KindW-1:0] KIND_STRLIT = 5'd7;
  localparam logic [KindW-1:0] KIND_INTLIT = 5'd8;
  localparam logic [KindW-1:0] KIND_FLTLIT = 5'd9;
  localparam logic [KindW-1:0] KIND_TSTR   = 5'd10;
  localparam logic [KindW-1:0] KIND_TINT   = 5'd11;
  localparam logic [KindW-1:0] KIND_TFLT   = 5'd12;
  localparam logic [KindW-1:0] KIND_LT     = 5'd13;
  localparam logic [KindW-1:0] KIND_LE     = 5'd14;
  localparam logic [KindW-1:0] KIND_GT     = 5'd15;
  localparam logic [KindW-1:0] KIND_GE     = 5'd16;
  localparam logic [KindW-1:0] KIND_STAR   = 5'd17;
  localparam logic [KindW-1:0] KIND_EOF    = 5'd18;

  // operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_INPUT = 2'd1;
  localparam logic [1:0] OP_OUT   = 2'd2;

  // element types
  localparam logic [1:0] T_INT = 2'd0;
  localparam logic [1:0] T_STR = 2'd1;
  localparam logic [1:0] T_FLT = 2'd2;

  // conditions
  localparam logic [2:0] COND_EQ  = 3'd0;
  localparam logic [2:0] COND_ANY = 3'd5;

  // error codes
  localparam logic [ErrW-1:0] E_BAD_OP    = 4'd0;
  localparam logic [ErrW-1:0] E_NO_EOF    = 4'd1;
  localparam logic [ErrW-1:0] E_NO_OPEN   = 4'd2;
  localparam logic [ErrW-1:0] E_NO_LIT    = 4'd3;
  localparam logic [ErrW-1:0] E_NO_CLOSE  = 4'd4;
  localparam logic [ErrW-1:0] E_NO_TYPE   = 4'd5;
  localparam logic [ErrW-1:0] E_NO_COLON  = 4'd6;
  localparam logic [ErrW-1:0] E_BAD_STR   = 4'd7;
  localparam logic [ErrW-1:0] E_BAD_INT   = 4'd8;
  localparam logic [ErrW-1:0] E_BAD_FLT   = 4'd9;
  localparam logic [ErrW-1:0] E_FLT_EQ    = 4'd10;
  localparam logic [ErrW-1:0] E_NO_VALUE  = 4'd11;

  // sequencer steps
  localparam logic [StepW-1:0] S_IDLE  = 4'd0;
  localparam logic [StepW-1:0] S_OPEN  = 4'd1;
  localparam logic [StepW-1:0] S_LIT   = 4'd2;
  localparam logic [StepW-1:0] S_SEP   = 4'd3;
  localparam logic [StepW-1:0] S_TYPE  = 4'd4;
  localparam logic [StepW-1:0] S_COLON = 4'd5;
  localparam logic [StepW-1:0] S_COND  = 4'd6;
  localparam logic [StepW-1:0] S_VALUE = 4'd7;
  localparam logic [StepW-1:0] S_EOF   = 4'd8;
  localparam logic [StepW-1:0] S_SKIP  = 4'd9;
  localparam logic [StepW-1:0] S_RD    = 4'd10;
  localparam logic [StepW-1:0] S_EMIT  = 4'd11;

  // token classes
  typedef enum logic [3:0] {
    CLS_OP, CLS_OPEN, CLS_CLOSE, CLS_COMMA, CLS_COLON, CLS_LIT,
    CLS_TYPE, CLS_CMP, CLS_STAR, CLS_EOF, CLS_OTHER
  } cls_e;

  localparam logic [NumCls-1:0] M_OP    = NumCls'(1) << CLS_OP;
  localparam logic [NumCls-1:0] M_OPEN  = NumCls'(1) << CLS_OPEN;
  localparam logic [NumCls-1:0] M_CLOSE = NumCls'(1) << CLS_CLOSE;
  localparam logic [NumCls-1:0] M_COMMA = NumCls'(1) << CLS_COMMA;
  localparam logic [NumCls-1:0] M_COLON = NumCls'(1) << CLS_COLON;
  localparam logic [NumCls-1:0] M_LIT   = NumCls'(1) << CLS_LIT;
  localparam logic [NumCls-1:0] M_TYPE  = NumCls'(1) << CLS_TYPE;
  localparam logic [NumCls-1:0] M_CMP   = NumCls'(1) << CLS_CMP;
  localparam logic [NumCls-1:0] M_STAR  = NumCls'(1) << CLS_STAR;
  localparam logic [NumCls-1:0] M_EOF   = NumCls'(1) << CLS_EOF;

  // element store selection
  typedef enum logic [1:0] {
    PUT_NONE, PUT_LIT, PUT_PAT
  } put_e;

  // one control word of the program
  typedef struct packed {
    logic              tok;
    logic [NumCls-1:0] ok_mask;
    logic [NumCls-1:0] alt_mask;
    logic [StepW-1:0]  next_ok;
    logic [StepW-1:0]  next_alt;
    logic              op_jump;
    logic [ErrW-1:0]   err;
    put_e              put;
    logic              clr;
    logic              set_op;
    logic              set_type;
    logic              set_cond;
    logic              chk_room;
    logic              chk_value;
    logic              rd_step;
    logic              emit_step;
  } uword_t;

  // input token
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic signed [31:0] token_int;
    logic [31:0]       token_float_bits;
    logic [15:0]       token_string_ref;
    logic [15:0]       token_line;
    logic [15:0]       token_col;
  } tok_t;

  // buffered element
  typedef struct packed {
    logic [1:0]  etype;
    logic [2:0]  cond;
    logic [31:0] value;
    logic [15:0] sref;
  } elem_t;

  // result item
  typedef struct packed {
    logic               is_error;
    logic               last_of_run;
    logic [1:0]         operation;
    logic [2:0]         element_index;
    logic [1:0]         element_type;
    logic [2:0]         condition;
    logic signed [31:0] int_value;
    logic [31:0]        float_bits;
    logic [15:0]        string_ref;
    logic [ErrW-1:0]    error_code;
    logic [15:0]        error_line;
    logic [15:0]        error_col;
  } res_t;

  // buffer control between sequencer and element buffer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } buf_ctl_t;

  // control program, one word per step
  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = '0;
    w.put = PUT_NONE;
    w.next_ok = S_IDLE;
    w.next_alt = S_IDLE;
    case (step)
      S_IDLE: begin
        w.tok = 1'b1; w.ok_mask = M_OP; w.next_ok = S_OPEN;
        w.err = E_BAD_OP; w.clr = 1'b1; w.set_op = 1'b1;
      end
      S_OPEN: begin
        w.tok = 1'b1; w.ok_mask = M_OPEN; w.op_jump = 1'b1; w.err = E_NO_OPEN;
      end
      S_LIT: begin
        w.tok = 1'b1; w.ok_mask = M_LIT; w.next_ok = S_SEP;
        w.err = E_NO_LIT; w.put = PUT_LIT;
      end
      S_SEP: begin
        w.tok = 1'b1; w.ok_mask = M_COMMA | M_CLOSE; w.alt_mask = M_CLOSE;
        w.next_alt = S_EOF; w.op_jump = 1'b1; w.err = E_NO_CLOSE;
        w.chk_room = 1'b1;
      end
      S_TYPE: begin
        w.tok = 1'b1; w.ok_mask = M_TYPE; w.next_ok = S_COLON;
        w.err = E_NO_TYPE; w.set_type = 1'b1;
      end
      S_COLON: begin
        w.tok = 1'b1; w.ok_mask = M_COLON; w.next_ok = S_COND; w.err = E_NO_COLON;
      end
      S_COND: begin
        w.tok = 1'b1; w.ok_mask = M_CMP | M_LIT | M_STAR; w.alt_mask = M_CMP;
        w.next_ok = S_SEP; w.next_alt = S_VALUE; w.err = E_NO_VALUE;
        w.set_cond = 1'b1; w.put = PUT_PAT; w.chk_value = 1'b1;
      end
      S_VALUE: begin
        w.tok = 1'b1; w.ok_mask = M_LIT | M_STAR; w.next_ok = S_SEP;
        w.err = E_NO_VALUE; w.put = PUT_PAT; w.chk_value = 1'b1;
      end
      S_EOF: begin
        w.tok = 1'b1; w.ok_mask = M_EOF; w.next_ok = S_RD; w.err = E_NO_EOF;
      end
      S_SKIP: begin
        w.tok = 1'b1; w.ok_mask = '1; w.alt_mask = M_EOF;
        w.next_ok = S_SKIP; w.next_alt = S_IDLE;
      end
      S_RD: begin
        w.rd_step = 1'b1; w.next_ok = S_EMIT;
      end
      S_EMIT: begin
        w.emit_step = 1'b1; w.next_ok = S_RD;
      end
      default: begin
        w.next_ok = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // token class of a kind
  function automatic cls_e tok_class(input logic [KindW-1:0] kind);
    cls_e c;
    case (kind)
      KIND_OUTPUT, KIND_INPUT, KIND_READ: c = CLS_OP;
      KIND_OPEN:                          c = CLS_OPEN;
      KIND_CLOSE:                         c = CLS_CLOSE;
      KIND_COMMA:                         c = CLS_COMMA;
      KIND_COLON:                         c = CLS_COLON;
      KIND_STRLIT, KIND_INTLIT, KIND_FLTLIT: c = CLS_LIT;
      KIND_TSTR, KIND_TINT, KIND_TFLT:    c = CLS_TYPE;
      KIND_LT, KIND_LE, KIND_GT, KIND_GE: c = CLS_CMP;
      KIND_STAR:                          c = CLS_STAR;
      KIND_EOF:                           c = CLS_EOF;
      default:                            c = CLS_OTHER;
    endcase
    return c;
  endfunction

  // operation of an operation token, read for anything else
  function automatic logic [1:0] op_code(input logic [KindW-1:0] kind);
    logic [1:0] op;
    case (kind)
      KIND_OUTPUT: op = OP_OUT;
      KIND_INPUT:  op = OP_INPUT;
      default:     op = OP_READ;
    endcase
    return op;
  endfunction

  // element type of a literal token
  function automatic logic [1:0] lit_type(input logic [KindW-1:0] kind);
    logic [1:0] t;
    case (kind)
      KIND_STRLIT: t = T_STR;
      KIND_INTLIT: t = T_INT;
      default:     t = T_FLT;
    endcase
    return t;
  endfunction

  // element type named by a type token
  function automatic logic [1:0] name_type(input logic [KindW-1:0] kind);
    logic [1:0] t;
    case (kind)
      KIND_TSTR: t = T_STR;
      KIND_TINT: t = T_INT;
      default:   t = T_FLT;
    endcase
    return t;
  endfunction

  // pattern literal check: {fail, code}
  function automatic logic [ErrW:0] value_check(input logic [KindW-1:0] kind,
                                                 input logic [1:0] ptype,
                                                 input logic [2:0] pcond);
    logic [ErrW:0] r;
    r = '0;
    case (kind)
      KIND_STRLIT: if (ptype != T_STR) r = {1'b1, E_BAD_STR};
      KIND_INTLIT: if (ptype != T_INT) r = {1'b1, E_BAD_INT};
      KIND_FLTLIT: begin
        if (ptype != T_FLT) r = {1'b1, E_BAD_FLT};
        else if (pcond == COND_EQ) r = {1'b1, E_FLT_EQ};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/trp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_if
// Token and result channels of the request token parser.
// ----------------------------------------------------------------------------

// token channel
interface trp_tok_if import trp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic signed [31:0] token_int;
  logic [31:0]        token_float_bits;
  logic [15:0]        token_string_ref;
  logic [15:0]        token_line;
  logic [15:0]        token_col;

  modport source (output valid, kind, token_int, token_float_bits,
                  token_string_ref, token_line, token_col, input ready);
  modport sink (input valid, kind, token_int, token_float_bits,
                token_string_ref, token_line, token_col, output ready);
endinterface

// result channel
interface trp_res_if import trp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_error;
  logic               last_of_run;
  logic [1:0]         operation;
  logic [2:0]         element_index;
  logic [1:0]         element_type;
  logic [2:0]         condition;
  logic signed [31:0] int_value;
  logic [31:0]        float_bits;
  logic [15:0]        string_ref;
  logic [ErrW-1:0]    error_code;
  logic [15:0]        error_line;
  logic [15:0]        error_col;

  modport source (output valid, is_error, last_of_run, operation, element_index,
                  element_type, condition, int_value, float_bits, string_ref,
                  error_code, error_line, error_col, input ready);
  modport sink (input valid, is_error, last_of_run, operation, element_index,
                element_type, condition, int_value, float_bits, string_ref,
                error_code, error_line, error_col, output ready);
endinterface

>>> src/trp_ebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_ebuf
// Element buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trp_ebuf import trp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef,
  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic             clk_i,
  input  buf_ctl_t         ctl_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  elem_t            wr_elem_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output elem_t            rd_elem_o
);

  elem_t mem_q [MAX_ELEMENTS];
  elem_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_elem_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_elem_o = rd_q;

endmodule

>>> src/trp_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_useq
// Microcoded sequencer: step counter, control program lookup, jump logic and
// the request registers; builds error and element results.
// ----------------------------------------------------------------------------
module trp_useq import trp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef,
  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  output logic             tok_ready_o,
  input  tok_t             tok_i,
  input  logic             res_free_i,
  output logic             res_load_o,
  output res_t             res_o,
  output buf_ctl_t         buf_ctl_o,
  output logic [AddrW-1:0] wr_addr_o,
  output elem_t            wr_elem_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  elem_t            rd_elem_i
);

  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       op_q, op_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [1:0]       ptype_q, ptype_d;
  logic [2:0]       pcond_q, pcond_d;

  uword_t            uw;
  cls_e              cls;
  logic [NumCls-1:0] cls_hot;
  logic              hit, alt, full, room_fail, acc, fail, last;
  logic [ErrW:0]     vchk;
  logic              vfail;
  logic [ErrW-1:0]   err_code;
  logic              is_lit_put;
  logic [31:0]       lit_value;

  // decode of current step and token
  always_comb begin
    uw        = ucode(step_q);
    cls       = tok_class(tok_i.kind);
    cls_hot   = NumCls'(1) << cls;
    hit       = |(uw.ok_mask & cls_hot);
    alt       = |(uw.alt_mask & cls_hot);
    full      = (count_q >= CntW'(MAX_ELEMENTS));
    room_fail = uw.chk_room && (cls == CLS_COMMA) && full;
    vchk      = value_check(tok_i.kind, ptype_q, pcond_q);
    vfail     = uw.chk_value && (cls == CLS_LIT) && vchk[ErrW];
    fail      = !hit || room_fail || vfail;
    err_code  = vfail ? vchk[ErrW-1:0] : uw.err;
    last      = ((CntW + 1)'(idx_q) + (CntW + 1)'(1)) == (CntW + 1)'(count_q);
    lit_value = (tok_i.kind == KIND_INTLIT) ? tok_i.token_int : tok_i.token_float_bits;
  end

  assign tok_ready_o = uw.tok && res_free_i;
  assign acc         = tok_valid_i && tok_ready_o;
  assign is_lit_put  = (uw.put != PUT_NONE) && (cls != CLS_CMP);

  // element to store
  always_comb begin
    wr_elem_o.etype = lit_type(tok_i.kind);
    wr_elem_o.cond  = (uw.put == PUT_PAT) ? pcond_q : COND_EQ;
    wr_elem_o.value = lit_value;
    wr_elem_o.sref  = tok_i.token_string_ref;
    if (cls == CLS_STAR) begin
      wr_elem_o.etype = ptype_q;
      wr_elem_o.cond  = COND_ANY;
      wr_elem_o.value = '0;
      wr_elem_o.sref  = '0;
    end
  end

  assign wr_addr_o = count_q[AddrW-1:0];
  assign rd_addr_o = idx_q[AddrW-1:0];

  // next step, request registers and result selection
  always_comb begin
    step_d     = step_q;
    op_d       = op_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ptype_d    = ptype_q;
    pcond_d    = pcond_q;
    res_load_o = 1'b0;
    buf_ctl_o  = '0;
    res_o      = '0;

    if (uw.rd_step) begin
      buf_ctl_o.rd_en = 1'b1;
      step_d = uw.next_ok;
    end

    // drain one buffered element
    if (uw.emit_step && res_free_i) begin
      res_load_o = 1'b1;
      idx_d = idx_q + CntW'(1);
      step_d = last ? S_IDLE : uw.next_ok;
    end
    if (uw.emit_step) begin
      res_o.last_of_run   = last;
      res_o.operation     = op_q;
      res_o.element_index = 3'(idx_q);
      res_o.element_type  = rd_elem_i.etype;
      res_o.condition     = rd_elem_i.cond;
      if (rd_elem_i.cond != COND_ANY) begin
        if (rd_elem_i.etype == T_INT) res_o.int_value = rd_elem_i.value;
        else if (rd_elem_i.etype == T_FLT) res_o.float_bits = rd_elem_i.value;
        else res_o.string_ref = rd_elem_i.sref;
      end
    end

    // one token step
    if (acc) begin
      idx_d = '0;
      if (uw.clr) begin
        count_d = '0;
        ptype_d = T_INT;
        pcond_d = COND_EQ;
      end
      if (uw.set_op) begin
        op_d = op_code(tok_i.kind);
      end
      if (fail) begin
        res_load_o        = 1'b1;
        res_o.is_error    = 1'b1;
        res_o.last_of_run = 1'b1;
        res_o.operation   = op_d;
        res_o.error_code  = err_code;
        res_o.error_line  = tok_i.token_line;
        res_o.error_col   = tok_i.token_col;
        step_d  = (cls == CLS_EOF) ? S_IDLE : S_SKIP;
        count_d = '0;
      end else begin
        if (alt) step_d = uw.next_alt;
        else if (uw.op_jump) step_d = (op_q == OP_OUT) ? S_LIT : S_TYPE;
        else step_d = uw.next_ok;
        if (uw.set_type) begin
          ptype_d = name_type(tok_i.kind);
          pcond_d = COND_EQ;
        end
        if (uw.set_cond && (cls == CLS_CMP)) begin
          pcond_d = 3'(tok_i.kind - KIND_LT) + 3'd1;
        end
        if (is_lit_put && !full) begin
          buf_ctl_o.wr_en = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= S_IDLE;
      op_q    <= OP_READ;
      count_q <= '0;
      idx_q   <= '0;
      ptype_q <= T_INT;
      pcond_q <= COND_EQ;
    end else begin
      step_q  <= step_d;
      op_q    <= op_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ptype_q <= ptype_d;
      pcond_q <= pcond_d;
    end
  end

endmodule

>>> src/tuple_request_token_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuple_request_token_parser
// Checks lexer tokens against the tuple-space request grammar and emits the
// buffered elements of a request, or one error result.
// ----------------------------------------------------------------------------
// Usage:
//   tok_i takes one lexer token per item (valid/ready). res_o gives result
//   items (valid/ready) from an output register.
//   After a grammar token that completes without a result, the next token can
//   be taken in the next cycle. The end-of-file token that closes
//   a valid request starts a drain of the element buffer: each element takes
//   a memory read step and then an output load step, which waits for a free
//   output register; no token is accepted during the drain.
//   An error result is loaded into the output register in the cycle its token
//   is accepted; later tokens are consumed silently up to end-of-file.
//   An error result passes through the output register only; an element result
//   passes through the buffer read register and then the output register.
//   Tokens are taken only while the output register is empty or being
//   emptied, so a stalled receiver stalls the token channel; nothing is lost.
//   Reset returns the sequencer to waiting for an operation token and empties
//   the output register; the buffer contents need no clearing.
// ----------------------------------------------------------------------------
module tuple_request_token_parser import trp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trp_tok_if.sink   tok_i,
  trp_res_if.source res_o
);

  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  tok_t             tok;
  res_t             res_d, res_q;
  logic             res_load, res_free;
  logic             out_valid_q;
  buf_ctl_t         buf_ctl;
  logic [AddrW-1:0] wr_addr, rd_addr;
  elem_t            wr_elem, rd_elem;

  // token payload
  always_comb begin
    tok.kind             = tok_i.kind;
    tok.token_int        = tok_i.token_int;
    tok.token_float_bits = tok_i.token_float_bits;
    tok.token_string_ref = tok_i.token_string_ref;
    tok.token_line       = tok_i.token_line;
    tok.token_col        = tok_i.token_col;
  end

  assign res_free = !out_valid_q || res_o.ready;

  trp_useq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_i.valid),
    .tok_ready_o (tok_i.ready),
    .tok_i       (tok),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_o       (res_d),
    .buf_ctl_o   (buf_ctl),
    .wr_addr_o   (wr_addr),
    .wr_elem_o   (wr_elem),
    .rd_addr_o   (rd_addr),
    .rd_elem_i   (rd_elem)
  );

  trp_ebuf #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ebuf (
    .clk_i     (clk_i),
    .ctl_i     (buf_ctl),
    .wr_addr_i (wr_addr),
    .wr_elem_i (wr_elem),
    .rd_addr_i (rd_addr),
    .rd_elem_o (rd_elem)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.is_error      = res_q.is_error;
  assign res_o.last_of_run   = res_q.last_of_run;
  assign res_o.operation     = res_q.operation;
  assign res_o.element_index = res_q.element_index;
  assign res_o.element_type  = res_q.element_type;
  assign res_o.condition     = res_q.condition;
  assign res_o.int_value     = res_q.int_value;
  assign res_o.float_bits    = res_q.float_bits;
  assign res_o.string_ref    = res_q.string_ref;
  assign res_o.error_code    = res_q.error_code;
  assign res_o.error_line    = res_q.error_line;
  assign res_o.error_col     = res_q.error_col;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tuple request token parser. A short table of
// directed tokens hits empty input, unknown tokens, value extremes, the
// float equality error and a wildcard pattern. Random requests follow:
// mostly well-formed with random content, plus noise, overflowing element
// lists and corrupted sequences. A parser model built into the bench predicts
// every result the table does not give, and both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import trp_pkg::*;

  localparam int MaxElems    = MaxElementsDef;
  localparam int CycleLimit  = 200000;
  localparam int TokenGoal   = 260;
  localparam int HoldoffAt   = 120;
  localparam int HoldoffLen  = 300;
  localparam int PauseFirst  = 60;
  localparam int PauseSecond = 200;
  localparam int DrainCycles = 2 * MaxElems + 8;
  localparam int ReportMax   = 10;
  localparam int ValueOk     = -1;

  // highest token kind, matching no grammar symbol
  localparam logic [KindW-1:0] KIND_OTHER_MAX = 5'd31;

  // parser phases of the model
  typedef enum logic [3:0] {
    PS_IDLE, PS_OPEN, PS_LIT, PS_SEP, PS_TYPE, PS_COLON, PS_COND, PS_VALUE,
    PS_EOF, PS_SKIP
  } parse_state_e;

  // one directed stimulus row
  typedef struct packed {
    tok_t tok;
    logic typed;
    res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  trp_tok_if tok_bus ();
  trp_res_if res_bus ();

  tuple_request_token_parser #(
    .MAX_ELEMENTS(MaxElems)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok_bus),
    .res_o (res_bus)
  );

  // model state
  parse_state_e ps = PS_IDLE;
  logic [1:0]   req_op = OP_READ;
  int           elem_cnt = 0;
  logic [1:0]   pend_type = T_INT;
  logic [2:0]   pend_cond = COND_EQ;
  elem_t        elem_buf [MaxElems];

  res_t     pending_results[$];
  dir_row_t dir_rows[$];

  int fail_cnt = 0;
  int tokens_taken = 0;
  int tokens_parsed = 0;
  int results_seen = 0;
  int errors_seen = 0;
  int requests_sent = 0;
  int cycle_cnt = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int recv_stall = 0;
  bit holdoff_done = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  // error result; ends the request and skips up to end-of-file
  function automatic res_t parse_error(input logic [ErrW-1:0] code, input tok_t t);
    res_t r;
    r = '0;
    r.is_error    = 1'b1;
    r.last_of_run = 1'b1;
    r.operation   = req_op;
    r.error_code  = code;
    r.error_line  = t.token_line;
    r.error_col   = t.token_col;
    ps = (t.kind == KIND_EOF) ? PS_IDLE : PS_SKIP;
    elem_cnt = 0;
    return r;
  endfunction

  // buffer one element, dropped once the buffer is full
  function automatic void buffer_elem(input logic [1:0] ty, input logic [2:0] cnd,
                                      input logic [31:0] value, input logic [15:0] sref);
    if (elem_cnt < MaxElems) begin
      elem_buf[elem_cnt].etype = ty;
      elem_buf[elem_cnt].cond  = cnd;
      elem_buf[elem_cnt].value = value;
      elem_buf[elem_cnt].sref  = sref;
      elem_cnt++;
    end
    ps = PS_SEP;
  endfunction

  // value of a pattern element: error code, or ValueOk when buffered
  function automatic int match_value(input tok_t t);
    case (t.kind)
      KIND_STAR: begin
        buffer_elem(pend_type, COND_ANY, '0, '0);
        return ValueOk;
      end
      KIND_STRLIT: begin
        if (pend_type != T_STR) return int'(E_BAD_STR);
        buffer_elem(T_STR, pend_cond, '0, t.token_string_ref);
        return ValueOk;
      end
      KIND_INTLIT: begin
        if (pend_type != T_INT) return int'(E_BAD_INT);
        buffer_elem(T_INT, pend_cond, t.token_int, '0);
        return ValueOk;
      end
      KIND_FLTLIT: begin
        if (pend_type != T_FLT) return int'(E_BAD_FLT);
        if (pend_cond == COND_EQ) return int'(E_FLT_EQ);
        buffer_elem(T_FLT, pend_cond, t.token_float_bits, '0);
        return ValueOk;
      end
      default: return int'(E_NO_VALUE);
    endcase
  endfunction

  // one token through the model; gives the results it causes
  task automatic parse_token(input tok_t t, output res_t outs[$], output bit ignored);
    int   code;
    res_t r;
    outs = {};
    ignored = (ps == PS_SKIP);
    case (ps)
      PS_IDLE: begin
        elem_cnt  = 0;
        pend_type = T_INT;
        pend_cond = COND_EQ;
        case (t.kind)
          KIND_OUTPUT: begin req_op = OP_OUT;   ps = PS_OPEN; end
          KIND_INPUT:  begin req_op = OP_INPUT; ps = PS_OPEN; end
          KIND_READ:   begin req_op = OP_READ;  ps = PS_OPEN; end
          default: begin
            req_op = OP_READ;
            outs.push_back(parse_error(E_BAD_OP, t));
          end
        endcase
      end
      PS_OPEN: begin
        if (t.kind == KIND_OPEN) ps = (req_op == OP_OUT) ? PS_LIT : PS_TYPE;
        else outs.push_back(parse_error(E_NO_OPEN, t));
      end
      PS_LIT: begin
        case (t.kind)
          KIND_STRLIT: buffer_elem(T_STR, COND_EQ, '0, t.token_string_ref);
          KIND_INTLIT: buffer_elem(T_INT, COND_EQ, t.token_int, '0);
          KIND_FLTLIT: buffer_elem(T_FLT, COND_EQ, t.token_float_bits, '0);
          default: outs.push_back(parse_error(E_NO_LIT, t));
        endcase
      end
      PS_SEP: begin
        if (t.kind == KIND_COMMA && elem_cnt < MaxElems)
          ps = (req_op == OP_OUT) ? PS_LIT : PS_TYPE;
        else if (t.kind == KIND_CLOSE) ps = PS_EOF;
        else outs.push_back(parse_error(E_NO_CLOSE, t));
      end
      PS_TYPE: begin
        case (t.kind)
          KIND_TSTR: begin pend_type = T_STR; pend_cond = COND_EQ; ps = PS_COLON; end
          KIND_TINT: begin pend_type = T_INT; pend_cond = COND_EQ; ps = PS_COLON; end
          KIND_TFLT: begin pend_type = T_FLT; pend_cond = COND_EQ; ps = PS_COLON; end
          default: outs.push_back(parse_error(E_NO_TYPE, t));
        endcase
      end
      PS_COLON: begin
        if (t.kind == KIND_COLON) ps = PS_COND;
        else outs.push_back(parse_error(E_NO_COLON, t));
      end
      PS_COND, PS_VALUE: begin
        if (ps == PS_COND && t.kind >= KIND_LT && t.kind <= KIND_GE) begin
          pend_cond = 3'(t.kind - KIND_LT + 5'd1);
          ps = PS_VALUE;
        end else begin
          code = match_value(t);
          if (code != ValueOk) outs.push_back(parse_error(ErrW'(code), t));
        end
      end
      PS_EOF: begin
        if (t.kind != KIND_EOF) begin
          outs.push_back(parse_error(E_NO_EOF, t));
        end else begin
          // drain the buffered run
          for (int k = 0; k < elem_cnt; k++) begin
            r = '0;
            r.last_of_run   = (k + 1 == elem_cnt);
            r.operation     = req_op;
            r.element_index = 3'(k);
            r.element_type  = elem_buf[k].etype;
            r.condition     = elem_buf[k].cond;
            if (elem_buf[k].cond != COND_ANY) begin
              case (elem_buf[k].etype)
                T_INT:   r.int_value  = elem_buf[k].value;
                T_FLT:   r.float_bits = elem_buf[k].value;
                default: r.string_ref = elem_buf[k].sref;
              endcase
            end
            outs.push_back(r);
          end
          ps = PS_IDLE;
          elem_cnt = 0;
        end
      end
      default: begin
        if (t.kind == KIND_EOF) begin
          ps = PS_IDLE;
          elem_cnt = 0;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tok_t mk_tok(input logic [KindW-1:0] kind, input logic [31:0] val,
                                  input logic [15:0] line, input logic [15:0] col);
    tok_t t;
    t.kind             = kind;
    t.token_int        = val;
    t.token_float_bits = val;
    t.token_string_ref = val[15:0];
    t.token_line       = line;
    t.token_col        = col;
    return t;
  endfunction

  function automatic res_t err_res(input logic [ErrW-1:0] code, input logic [1:0] op,
                                   input logic [15:0] line, input logic [15:0] col);
    res_t r;
    r = '0;
    r.is_error    = 1'b1;
    r.last_of_run = 1'b1;
    r.operation   = op;
    r.error_code  = code;
    r.error_line  = line;
    r.error_col   = col;
    return r;
  endfunction

  task automatic add_row(input tok_t t, input logic typed, input res_t want);
    dir_row_t d;
    d.tok   = t;
    d.typed = typed;
    d.want  = want;
    dir_rows.push_back(d);
  endtask

  function automatic tok_t rand_tok(input logic [KindW-1:0] kind);
    tok_t t;
    t.kind             = kind;
    t.token_int        = $urandom;
    t.token_float_bits = $urandom;
    t.token_string_ref = 16'($urandom);
    t.token_line       = 16'($urandom);
    t.token_col        = 16'($urandom);
    return t;
  endfunction

  function automatic logic [KindW-1:0] any_literal();
    case ($urandom_range(0, 2))
      0:       return KIND_STRLIT;
      1:       return KIND_INTLIT;
      default: return KIND_FLTLIT;
    endcase
  endfunction

  // one random request: mostly well-formed, some noise, overflow or damage
  task automatic make_request(output tok_t seq[$]);
    int               n;
    int               r;
    int               p;
    logic [KindW-1:0] op_kind;
    logic [KindW-1:0] ty_kind;
    logic [KindW-1:0] lit_kind;
    bit               with_cmp;
    seq = {};
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // noise tokens then end-of-file
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back(rand_tok(KindW'($urandom_range(0, KIND_OTHER_MAX))));
      seq.push_back(rand_tok(KIND_EOF));
      return;
    end
    case ($urandom_range(0, 2))
      0:       op_kind = KIND_OUTPUT;
      1:       op_kind = KIND_INPUT;
      default: op_kind = KIND_READ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 75) n = $urandom_range(1, 4);
    else if (r < 92) n = $urandom_range(5, MaxElems);
    else n = MaxElems + 1;
    seq.push_back(rand_tok(op_kind));
    seq.push_back(rand_tok(KIND_OPEN));
    for (int i = 0; i < n; i++) begin
      if (i > 0) seq.push_back(rand_tok(KIND_COMMA));
      if (op_kind == KIND_OUTPUT) begin
        seq.push_back(rand_tok(any_literal()));
      end else begin
        case ($urandom_range(0, 2))
          0:       begin ty_kind = KIND_TSTR; lit_kind = KIND_STRLIT; end
          1:       begin ty_kind = KIND_TINT; lit_kind = KIND_INTLIT; end
          default: begin ty_kind = KIND_TFLT; lit_kind = KIND_FLTLIT; end
        endcase
        seq.push_back(rand_tok(ty_kind));
        seq.push_back(rand_tok(KIND_COLON));
        with_cmp = 1'($urandom_range(0, 1));
        if (with_cmp) seq.push_back(rand_tok(KIND_LT + KindW'($urandom_range(0, 3))));
        r = $urandom_range(0, 99);
        if (r < 25) begin
          seq.push_back(rand_tok(KIND_STAR));
        end else if (r < 35) begin
          // any literal, type may not match
          seq.push_back(rand_tok(any_literal()));
        end else begin
          if (lit_kind == KIND_FLTLIT && !with_cmp) seq.push_back(rand_tok(KIND_GT));
          seq.push_back(rand_tok(lit_kind));
        end
      end
    end
    seq.push_back(rand_tok(KIND_CLOSE));
    seq.push_back(rand_tok(KIND_EOF));
    // damage some requests: replace, drop or insert one token
    if ($urandom_range(0, 99) < 20) begin
      p = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 2))
        0:       seq[p].kind = KindW'($urandom_range(0, KIND_OTHER_MAX));
        1:       seq.delete(p);
        default: seq.insert(p, rand_tok(KindW'($urandom_range(0, KIND_OTHER_MAX))));
      endcase
    end
  endtask

  // sender gap: mostly none or short, a few long, some calm stretches
  function automatic int send_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) send_calm = $urandom_range(15, 50);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one token, wait for the handshake, then run the model
  task automatic send_token(input tok_t t, output res_t outs[$], output bit ignored);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      tok_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tok_bus.valid            <= 1'b1;
    tok_bus.kind             <= t.kind;
    tok_bus.token_int        <= t.token_int;
    tok_bus.token_float_bits <= t.token_float_bits;
    tok_bus.token_string_ref <= t.token_string_ref;
    tok_bus.token_line       <= t.token_line;
    tok_bus.token_col        <= t.token_col;
    @(posedge clk_i);
    while (!tok_bus.ready) @(posedge clk_i);
    tokens_taken++;
    parse_token(t, outs, ignored);
  endtask

  // stop sending until every predicted result has come
  task automatic wait_drained();
    tok_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic string res_text(input res_t r);
    return {$sformatf("err=%0d last=%0d op=%0d idx=%0d type=%0d cond=%0d ",
                      r.is_error, r.last_of_run, r.operation, r.element_index,
                      r.element_type, r.condition),
            $sformatf("int=%08h flt=%08h sref=%04h code=%0d line=%0d col=%0d",
                      r.int_value, r.float_bits, r.string_ref, r.error_code,
                      r.error_line, r.error_col)};
  endfunction

  // ---------------------------------------------------------------------------
  // token sender
  // ---------------------------------------------------------------------------
  initial begin
    tok_t req[$];
    res_t outs[$];
    bit   ignored;
    int   pauses;
    pauses = 0;
    rst_ni = 1'b0;
    tok_bus.valid            = 1'b0;
    tok_bus.kind             = '0;
    tok_bus.token_int        = '0;
    tok_bus.token_float_bits = '0;
    tok_bus.token_string_ref = '0;
    tok_bus.token_line       = '0;
    tok_bus.token_col        = '0;

    // directed tokens
    add_row(mk_tok(KIND_EOF, '0, 16'hFFFF, 16'hFFFF), 1'b1,
            err_res(E_BAD_OP, OP_READ, 16'hFFFF, 16'hFFFF));
    add_row(mk_tok(KIND_OTHER_MAX, '1, 16'd0, 16'd0), 1'b1,
            err_res(E_BAD_OP, OP_READ, 16'd0, 16'd0));
    add_row(mk_tok(KIND_EOF, '0, 16'd1, 16'd3), 1'b0, '0);
    add_row(mk_tok(KIND_OUTPUT, '0, 16'd2, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_OPEN, '0, 16'd2, 16'd7), 1'b0, '0);
    add_row(mk_tok(KIND_INTLIT, 32'h8000_0000, 16'd2, 16'd8), 1'b0, '0);
    add_row(mk_tok(KIND_COMMA, '0, 16'd2, 16'd19), 1'b0, '0);
    add_row(mk_tok(KIND_STRLIT, 32'hFFFF_FFFF, 16'd2, 16'd21), 1'b0, '0);
    add_row(mk_tok(KIND_CLOSE, '0, 16'd2, 16'd30), 1'b0, '0);
    add_row(mk_tok(KIND_EOF, '0, 16'd3, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_READ, '0, 16'd4, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_OPEN, '0, 16'd4, 16'd5), 1'b0, '0);
    add_row(mk_tok(KIND_TFLT, '0, 16'd4, 16'd6), 1'b0, '0);
    add_row(mk_tok(KIND_COLON, '0, 16'd4, 16'd11), 1'b0, '0);
    add_row(mk_tok(KIND_FLTLIT, 32'h7F80_0000, 16'd14, 16'd3), 1'b1,
            err_res(E_FLT_EQ, OP_READ, 16'd14, 16'd3));
    add_row(mk_tok(KIND_EOF, '0, 16'd5, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_INPUT, '0, 16'd6, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_OPEN, '0, 16'd6, 16'd3), 1'b0, '0);
    add_row(mk_tok(KIND_TSTR, '0, 16'd6, 16'd4), 1'b0, '0);
    add_row(mk_tok(KIND_COLON, '0, 16'd6, 16'd10), 1'b0, '0);
    add_row(mk_tok(KIND_GE, '0, 16'd6, 16'd11), 1'b0, '0);
    add_row(mk_tok(KIND_STAR, '0, 16'd6, 16'd13), 1'b0, '0);
    add_row(mk_tok(KIND_CLOSE, '0, 16'd6, 16'd14), 1'b0, '0);
    add_row(mk_tok(KIND_EOF, '0, 16'd7, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_INPUT, '0, 16'd8, 16'd1), 1'b0, '0);
    add_row(mk_tok(KIND_COMMA, '0, 16'd25, 16'd7), 1'b1,
            err_res(E_NO_OPEN, OP_INPUT, 16'd25, 16'd7));
    add_row(mk_tok(KIND_EOF, '0, 16'd9, 16'd1), 1'b0, '0);

    // reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[i]) begin
      send_token(dir_rows[i].tok, outs, ignored);
      if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].want);
      else foreach (outs[j]) pending_results.push_back(outs[j]);
    end
    wait_drained();

    // random requests, with two full drains along the way
    while (tokens_taken < TokenGoal) begin
      make_request(req);
      requests_sent++;
      foreach (req[i]) begin
        send_token(req[i], outs, ignored);
        foreach (outs[j]) pending_results.push_back(outs[j]);
        if (!ignored) tokens_parsed++;
      end
      if ((pauses == 0 && tokens_taken >= PauseFirst) ||
          (pauses == 1 && tokens_taken >= PauseSecond)) begin
        wait_drained();
        pauses++;
      end
    end

    // end of run
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d random requests and %0d tokens in all, %0d of them parsed",
             requests_sent, tokens_taken, tokens_parsed);
    $display("checked %0d results, %0d of them errors; %0d failures", results_seen,
             errors_seen, fail_cnt);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    res_t got;
    res_t want;
    int   r;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      // compare each accepted result with the oldest prediction
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        got.is_error      = res_bus.is_error;
        got.last_of_run   = res_bus.last_of_run;
        got.operation     = res_bus.operation;
        got.element_index = res_bus.element_index;
        got.element_type  = res_bus.element_type;
        got.condition     = res_bus.condition;
        got.int_value     = res_bus.int_value;
        got.float_bits    = res_bus.float_bits;
        got.string_ref    = res_bus.string_ref;
        got.error_code    = res_bus.error_code;
        got.error_line    = res_bus.error_line;
        got.error_col     = res_bus.error_col;
        results_seen++;
        if (got.is_error) errors_seen++;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= ReportMax) $display("unexpected result: %s", res_text(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= ReportMax) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected %s", res_text(want));
              $display("  actual   %s", res_text(got));
            end
          end
        end
      end
      // ready: random stalls, calm stretches and one long hold-off
      if (!rst_ni) begin
        res_bus.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        res_bus.ready <= 1'b0;
        recv_stall--;
      end else if (!holdoff_done && tokens_taken >= HoldoffAt) begin
        holdoff_done = 1'b1;
        recv_stall = HoldoffLen;
        res_bus.ready <= 1'b0;
      end else if (recv_calm > 0) begin
        res_bus.ready <= 1'b1;
        recv_calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) recv_calm = $urandom_range(20, 60);
        if (r < 70) begin
          res_bus.ready <= 1'b1;
        end else begin
          res_bus.ready <= 1'b0;
          recv_stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt <= CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/trp_pkg.sv
src/trp_if.sv
src/trp_ebuf.sv
src/trp_useq.sv
src/tuple_request_token_parser.sv
sim/testbench.sv
